>>> hdl/sha256_byte_stream_hasher_defines.svh
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/shs_pkg.sv
package shs_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned NumRounds = 64;
    localparam int unsigned DigestWords = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    typedef logic [31:0] t_word;

    localparam t_word InitHash [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hdl/sha256_byte_stream_hasher.sv
// channel   dir  tdata                                tuser
// s_axis    in   [7:0] data_byte                      [0] has_byte
//                                                     tlast = end_of_message
// m_axis    out  [31:0] digest_word                   [2:0] word_index
//                                                     tlast = last_word
// bytes enter a small queue at one per cycle while it has room; the core
// drains it one byte per cycle while in its take state and runs 64 rounds
// and a fold step per block. message end pads out the block, and a second
// block when the length spills, then gives 8 output transactions. reset is
// synchronous, active low, and restores the initial hash words. a stalled
// output holds the core; input stalls only when the queue fills.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher
    import shs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    logic  q_full, q_empty, q_pop, push;
    t_item in_item, q_item;

    assign s_axis_tready = !q_full;
    assign push = s_axis_tvalid && !q_full;
    assign in_item = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                       end_of_message: s_axis_tlast};

    shs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_item(in_item), .o_full(q_full),
        .i_pop(q_pop), .o_item(q_item), .o_empty(q_empty)
    );

    shs_core u_core (
        .i_clk, .i_rst_n,
        .i_q_empty(q_empty), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_digest_word(m_axis_tdata), .o_word_index(m_axis_tuser),
        .o_last_word(m_axis_tlast)
    );

    `SHS_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == 3'd7, "last word must be index 7")
    `SHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tuser), "output word changed while stalled")
    `SHS_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty,
        "core popped an empty queue")
endmodule

>>> hdl/shs_queue.sv
module shs_queue
    import shs_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_item;
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

>>> hdl/shs_core.sv
module shs_core
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    typedef enum logic [2:0] {
        S_TAKE, S_PAD, S_ROUND, S_FOLD, S_EMIT
    } t_state;

    t_state       r_state;
    t_word        r_h [DigestWords];
    t_word        r_v [8];
    t_word        r_w [16];
    logic [5:0]   r_fill;
    logic [60:0]  r_bytes;
    logic [5:0]   r_rnd;
    logic         r_final;   // compressing the block that closes the message
    logic         r_more;    // the 0x80 pad byte is still to be written
    logic         r_spill;   // 0x80 landed past byte 55, length goes in the next block
    logic [2:0]   r_idx;

    t_word big0, big1, ch, maj, t1, t2, s0, s1, w_new, w_cur;
    logic [63:0] bitlen;
    logic [1:0]  bsel;
    logic [3:0]  wsel;
    logic        pad_spill;

    assign o_q_pop = (r_state == S_TAKE) && !i_q_empty;
    assign bitlen  = {r_bytes, 3'b000};
    assign wsel    = r_fill[5:2];
    assign bsel    = r_fill[1:0];
    assign pad_spill = r_more ? (r_fill >= 6'd56) : r_spill;

    always_comb begin
        w_cur = r_w[0];
        big1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big1 + ch + round_k(r_rnd) + w_cur;
        t2    = big0 + maj;
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
    end

    assign o_out_valid   = (r_state == S_EMIT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
            r_fill  <= '0;
            r_bytes <= '0;
            r_rnd   <= '0;
            r_final <= 1'b0;
            r_more  <= 1'b0;
            r_spill <= 1'b0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (!i_q_empty) begin
                        if (i_q_item.has_byte) begin
                            r_w[wsel][8*(3-bsel) +: 8] <= i_q_item.data_byte;
                            r_bytes <= r_bytes + 61'd1;
                            r_fill  <= r_fill + 6'd1;
                        end
                        r_final <= 1'b0;
                        if (i_q_item.has_byte && r_fill == 6'd63) begin
                            r_more  <= i_q_item.end_of_message;
                            r_state <= S_ROUND;
                            r_rnd   <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end else if (i_q_item.end_of_message) begin
                            r_state <= S_PAD;
                            r_more  <= 1'b1;
                        end
                    end
                end
                S_PAD: begin
                    // r_more set: next pad byte is 0x80 when fill marks it
                    if (r_more) begin
                        r_w[wsel][8*(3-bsel) +: 8] <= PadByte;
                        r_more  <= 1'b0;
                        r_spill <= (r_fill >= 6'd56);
                    end else if (!r_spill && r_fill >= 6'd56) begin
                        r_w[wsel][8*(3-bsel) +: 8] <=
                            bitlen[8*(7-(r_fill-6'd56)) +: 8];
                    end else begin
                        r_w[wsel][8*(3-bsel) +: 8] <= 8'h00;
                    end
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_final <= !pad_spill;
                        r_state <= S_ROUND;
                        r_rnd   <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'(NumRounds - 1)) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx   <= '0;
                    r_spill <= 1'b0;
                    if (r_final) begin
                        r_state <= S_EMIT;
                    end else if (r_more || r_spill) begin
                        r_state <= S_PAD;   // message ended on a full block or padding spilled
                    end else begin
                        r_state <= S_TAKE;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
                            r_bytes <= '0;
                            r_fill  <= '0;
                            r_final <= 1'b0;
                            r_state <= S_TAKE;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

>>> bench/tb_top.sv
module tb_top;
    import shs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha256_byte_stream_hasher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    logic [6:0]  blk_fill;
    logic [60:0] msg_len;

    byte_item_t  pending_items [$];
    digest_out_t expected_words [$];
    int          n_items, n_words, n_msgs, n_errors;
    bit          stim_done, sender_hold;
    int          hold_off_cycles;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
        blk_fill = '0;
        msg_len = '0;
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    // feeds one accepted item and queues the digest words it produces
    function automatic void hash_take(byte_item_t it);
        logic [63:0] bit_len;
        int pos;
        digest_out_t d;
        if (it.has_byte) begin
            blk_bytes[blk_fill[5:0]] = it.data_byte;
            blk_fill++;
            msg_len++;
            if (blk_fill >= 64) begin
                compress_blk();
                blk_fill = '0;
            end
        end
        if (!it.end_of_message) return;
        n_msgs++;
        bit_len = {msg_len, 3'b000};
        pos = blk_fill;
        blk_bytes[pos++] = PadByte;
        if (pos > 56) begin
            while (pos < 64) blk_bytes[pos++] = 8'h00;
            compress_blk();
            pos = 0;
        end
        while (pos < 56) blk_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
        compress_blk();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_state[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            expected_words.push_back(d);
        end
        restart_hash();
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_item(logic [7:0] b, logic hb, logic eom);
        byte_item_t it;
        it.data_byte = b;
        it.has_byte = hb;
        it.end_of_message = eom;
        pending_items.push_back(it);
    endfunction

    function automatic void add_message(int len, bit end_empty, bit noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, !end_empty && i == len - 1);
        end
        if (end_empty || len == 0) add_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    // driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                hash_take(byte_item_t'({s_axis_tdata, s_axis_tuser, s_axis_tlast}));
                n_items++;
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && !sender_hold) begin
                byte_item_t it;
                it = pending_items.pop_front();
                s_axis_tdata <= it.data_byte;
                s_axis_tuser <= it.has_byte;
                s_axis_tlast <= it.end_of_message;
                s_axis_tvalid <= 1'b1;
                in_gap <= gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and output stalls
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_words++;
                if (expected_words.size() == 0) begin
                    $error("unexpected digest word %08h", m_axis_tdata);
                    n_errors++;
                end else begin
                    digest_out_t e;
                    e = expected_words.pop_front();
                    if (m_axis_tdata !== e.digest_word) begin
                        $error("digest_word exp %08h got %08h", e.digest_word, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tuser !== e.word_index) begin
                        $error("word_index exp %0d got %0d", e.word_index, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tlast !== e.last_word) begin
                        $error("last_word exp %0d got %0d", e.last_word, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                out_gap <= gap_len();
            end
        end
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int guard;
        n_items = 0; n_words = 0; n_msgs = 0; n_errors = 0;
        stim_done = 0; sender_hold = 0; hold_off_cycles = 0;
        restart_hash();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, "abc"-like edge bytes, ignored item
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h55, 1'b1, 1'b1);
        add_item(8'haa, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        // padding boundaries: 55 fits in one block, 56 spills into two
        add_message(55, 0, 0);
        add_message(56, 0, 0);
        add_message(64, 1, 0);

        // long hold-off on the output side while bytes keep coming
        hold_off_cycles = 400;
        add_message(40, 0, 0);
        while (pending_items.size() > 0) @(posedge i_clk);

        // sender pauses until every digest is back
        sender_hold = 1;
        guard = 0;
        while ((expected_words.size() > 0 || s_axis_tvalid) && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        sender_hold = 0;

        // random messages, mostly short with an occasional multi-block one
        for (int m = 0; m < 3; m++) begin
            int len;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
            add_message(len, $urandom_range(0, 3) == 0, 1);
        end
        while (pending_items.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        stim_done = 1;

        guard = 0;
        while (expected_words.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_words.size() > 0) begin
            $display("TEST FAILED");
            $finish;
        end
        repeat (300) @(posedge i_clk);

        $display("covered %0d input transactions, %0d messages, %0d digest words",
                 n_items, n_msgs, n_words);
        $display("messages spanned empty, one-block and two-block padding with stalls");
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
